/* design/ckm_pkg.sv */
// package: shared types, base codes and character decode for the canonical k-mer stream
`timescale 1ns / 1ps
`default_nettype none

package ckm_pkg;

  // widest window the output fields carry, and the position field width
  localparam int WIN_MAX_BITS = 102;
  localparam int HIGH_BITS    = 38;
  localparam int LOW_BITS     = 64;
  localparam int POS_OUT_BITS = 32;

  // ascii characters that count as bases
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } ckm_base_t;

  // one queued k-mer: both windows zero-extended, plus offset of the newest base
  typedef struct packed {
    logic [WIN_MAX_BITS-1:0] fwd;
    logic [WIN_MAX_BITS-1:0] rc;
    logic [POS_OUT_BITS-1:0] here;
  } ckm_entry_t;

  function automatic ckm_base_t ckm_decode(input logic [7:0] c);
    ckm_base_t r;
    r.ok   = 1'b1;
    r.code = BASE_A;
    unique case (c)
      CHAR_A: r.code = BASE_A;
      CHAR_C: r.code = BASE_C;
      CHAR_G: r.code = BASE_G;
      CHAR_T: r.code = BASE_T;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ckm_front.sv */
// front: base decode, rolling forward/revcomp windows, run count and record offset
`timescale 1ns / 1ps
`default_nettype none

module ckm_front
  import ckm_pkg::*;
#(
  parameter int KMER_LEN = 51,
  parameter int POS_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] base_char,
  input  wire logic       record_start,
  input  wire logic       q_full,
  output logic            q_push,
  output ckm_entry_t      q_entry
);

  localparam int WIN_BITS = 2 * KMER_LEN;
  localparam int OFF_W    = (POS_BITS < 32) ? POS_BITS : 32;
  localparam int CNT_W    = $clog2(KMER_LEN + 1);

  logic [WIN_BITS-1:0] fwd, fwd_next;
  logic [WIN_BITS-1:0] rc, rc_next;
  logic [CNT_W-1:0]    vcount, vcount_next;
  logic [OFF_W-1:0]    offset, offset_next;

  logic [WIN_BITS-1:0] fwd_base, rc_base;
  logic [CNT_W-1:0]    vcount_base;
  logic [OFF_W-1:0]    here;
  ckm_base_t           dec;
  logic                accept;
  logic                emit;

  assign in_ready = !q_full && !rst;
  assign accept   = in_valid && in_ready;
  assign dec      = ckm_decode(base_char);

  always_comb begin
    // a record start clears the run before this character is taken
    fwd_base    = record_start ? '0 : fwd;
    rc_base     = record_start ? '0 : rc;
    vcount_base = record_start ? '0 : vcount;
    here        = record_start ? '0 : offset;

    offset_next = (here != {OFF_W{1'b1}}) ? here + OFF_W'(1) : here;

    fwd_next    = fwd_base;
    rc_next     = rc_base;
    vcount_next = '0;
    emit        = 1'b0;
    if (dec.ok) begin
      fwd_next    = WIN_BITS'({fwd_base, dec.code});
      rc_next     = (rc_base >> 2) | (WIN_BITS'(~dec.code) << (WIN_BITS - 2));
      vcount_next = (vcount_base < CNT_W'(KMER_LEN)) ? vcount_base + CNT_W'(1)
                                                      : vcount_base;
      emit        = (vcount_next == CNT_W'(KMER_LEN));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd    <= '0;
      rc     <= '0;
      vcount <= '0;
      offset <= '0;
    end else if (accept) begin
      fwd    <= fwd_next;
      rc     <= rc_next;
      vcount <= vcount_next;
      offset <= offset_next;
    end
  end

  assign q_push       = accept && emit;
  assign q_entry.fwd  = WIN_MAX_BITS'(fwd_next);
  assign q_entry.rc   = WIN_MAX_BITS'(rc_next);
  assign q_entry.here = POS_OUT_BITS'(here);

endmodule

`default_nettype wire

/* design/ckm_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module ckm_queue
  import ckm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire ckm_entry_t push_entry,
  input  wire logic       pop,
  output logic            full,
  output logic            avail,
  output ckm_entry_t      head
);

  ckm_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ckm_back.sv */
// back: canonical select, start position and output register
`timescale 1ns / 1ps
`default_nettype none

module ckm_back
  import ckm_pkg::*;
#(
  parameter int KMER_LEN = 51
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_avail,
  input  wire ckm_entry_t   q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata
);

  localparam logic [POS_OUT_BITS-1:0] SPAN = POS_OUT_BITS'(KMER_LEN - 1);

  logic [WIN_MAX_BITS-1:0] canon;
  logic [POS_OUT_BITS-1:0] start;
  logic                    load;

  assign load  = q_avail && (!m_tvalid || m_tready);
  assign q_pop = load;

  always_comb begin
    // equal windows fall through to forward, which is the same code
    canon = (q_head.rc < q_head.fwd) ? q_head.rc : q_head.fwd;
    start = (q_head.here >= SPAN) ? q_head.here - SPAN : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, start, canon[LOW_BITS-1:0],
                  canon[WIN_MAX_BITS-1:LOW_BITS]};
    end
  end

endmodule

`default_nettype wire

/* design/canonical_kmer_stream.sv */
// top level: canonical k-mer stream, front window unit, queue and back select
// path: an accepted base word's k-mer goes through the queue and then the output register to the master side
// throughput: one base word per cycle while the queue is not full, set by the window update in the front
// the two-entry queue ahead of the back compare lets the output stall without stopping the input until it is full
// reset: synchronous, clears both windows, run count, record offset, queue and output valid
// s_tready is held low while rst is high
`timescale 1ns / 1ps
`default_nettype none

module canonical_kmer_stream
  import ckm_pkg::*;
#(
  parameter int KMER_LEN = 51,  // bases per k-mer, 1 to 51
  parameter int POS_BITS = 32   // offset counter width, limited to 32; the offset saturates at all ones
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input words: one ascii character each
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] base_char
  input  wire logic         s_tuser,   // [0] record_start
  // output words: one canonical k-mer each
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata    // [37:0] kmer_high, [101:38] kmer_low,
                                       // [133:102] kmer_position, [135:134] zero
);

  // front to queue
  logic       q_full;
  logic       q_push;
  ckm_entry_t q_entry;

  // queue to back
  logic       q_avail;
  logic       q_pop;
  ckm_entry_t q_head;

  // front: decodes the character, rolls both windows on every accepted base,
  // and queues a k-mer for each base while a full run of valid bases is held
  ckm_front #(
    .KMER_LEN (KMER_LEN),
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .base_char    (s_tdata),
    .record_start (s_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // short queue decouples window updates from output back-pressure
  ckm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .avail      (q_avail),
    .head       (q_head)
  );

  // back: wide compare picks the smaller window, start offset is backed off
  // by the k-mer length less one, result lands in the output register
  ckm_back #(
    .KMER_LEN (KMER_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* design/ckm_checker.sv */
// checker: port-level assertions for the canonical k-mer stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ckm_checker
  import ckm_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [7:0]   s_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata
);

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");

  // pad bits above the position stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[135:134] == 2'b00))
    else $error("output pad bits not zero");

  // a fresh output word comes from an accepted valid base that has passed the queue and the output register
  a_rise_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |->
      ($past(s_tvalid && s_tready, 2) &&
       ($past(s_tdata, 2) == CHAR_A || $past(s_tdata, 2) == CHAR_C ||
        $past(s_tdata, 2) == CHAR_G || $past(s_tdata, 2) == CHAR_T)))
    else $error("output word without a matching accepted base");

endmodule

bind canonical_kmer_stream ckm_checker u_ckm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb_top.sv */
// testbench for canonical_kmer_stream: directed and random character streams checked word by word
`timescale 1ns / 1ps

module tb_top;
  import ckm_pkg::*;

  // offset counter at 16 bits, narrower than the position field
  localparam int KMER_LEN = 51;
  localparam int POS_BITS = 16;
  localparam int WIN_BITS = 2 * KMER_LEN;
  localparam logic [WIN_MAX_BITS-1:0] WIN_MASK = {WIN_MAX_BITS{1'b1}} >> (WIN_MAX_BITS - WIN_BITS);
  localparam logic [POS_OUT_BITS-1:0] POS_MAX =
    (POS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << POS_BITS) - 64'd1);
  localparam int IDLE_PCT    = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;

  // one expected k-mer word
  typedef struct {
    logic [HIGH_BITS-1:0]    hi;
    logic [LOW_BITS-1:0]     lo;
    logic [POS_OUT_BITS-1:0] pos;
  } kmer_word_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;

  // predictor state: both windows, run of valid bases, offset in the record
  logic [WIN_MAX_BITS-1:0] fwd_win;
  logic [WIN_MAX_BITS-1:0] rc_win;
  int                      base_run;
  logic [POS_OUT_BITS-1:0] rec_offset;

  kmer_word_t pending_kmers[$];

  int  sent_words;
  int  checked_kmers;
  int  error_count;
  int  cycle_count;
  bit  idle_on;    // random idling on both sides
  bit  hold_req;   // asks the receiver for one long stall

  canonical_kmer_stream #(
    .KMER_LEN(KMER_LEN),
    .POS_BITS(POS_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d k-mers still pending", cycle_count,
               pending_kmers.size());
      $display("canonical_kmer_stream: mismatch");
      $finish;
    end
  end

  // expected k-mers: roll both windows by one accepted character
  task automatic advance_windows(input logic [7:0] c, input logic rec_start);
    logic [1:0]              code;
    logic                    is_base;
    logic [POS_OUT_BITS-1:0] here;
    logic [WIN_MAX_BITS-1:0] canon;
    kmer_word_t              k;
    if (rec_start) begin
      fwd_win    = '0;
      rc_win     = '0;
      base_run   = 0;
      rec_offset = '0;
    end
    here = rec_offset;
    if (rec_offset < POS_MAX) rec_offset = rec_offset + 1;
    is_base = 1'b1;
    code    = BASE_A;
    case (c)
      CHAR_A: code = BASE_A;
      CHAR_C: code = BASE_C;
      CHAR_G: code = BASE_G;
      CHAR_T: code = BASE_T;
      default: is_base = 1'b0;
    endcase
    // anything else breaks the run but still takes a position
    if (!is_base) begin
      base_run = 0;
      return;
    end
    fwd_win = ((fwd_win << 2) | WIN_MAX_BITS'(code)) & WIN_MASK;
    // complement of the newest base enters at the top of the reverse window
    rc_win  = (rc_win >> 2) | (WIN_MAX_BITS'(~code) << (WIN_BITS - 2));
    if (base_run < KMER_LEN) base_run++;
    if (base_run == KMER_LEN) begin
      canon = (rc_win < fwd_win) ? rc_win : fwd_win;
      k.hi  = canon[WIN_MAX_BITS-1:LOW_BITS];
      k.lo  = canon[LOW_BITS-1:0];
      k.pos = here - POS_OUT_BITS'(KMER_LEN - 1);
      pending_kmers = {pending_kmers, k};
    end
  endtask

  // send one character word; entered and left just after a falling edge
  task automatic push_char(input logic [7:0] c, input logic rec_start);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= rec_start;
    do @(posedge clk); while (!s_tready);
    advance_windows(c, rec_start);
    sent_words++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(3))
      0: return CHAR_A;
      1: return CHAR_C;
      2: return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  function automatic logic [7:0] pick_non_base();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CHAR_A || c == CHAR_C || c == CHAR_G || c == CHAR_T);
    return c;
  endfunction

  // receiver: random stalls, or one long counted hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // checker: every accepted k-mer word against the oldest expectation
  always @(posedge clk) begin : kmer_check
    kmer_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_kmers.size() == 0) begin
        error_count++;
        $display("%0t: unexpected k-mer word, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_kmers.pop_front();
        checked_kmers++;
        if (m_tdata[37:0] !== want.hi) begin
          error_count++;
          $display("%0t: kmer_high expected %h actual %h", $time, want.hi, m_tdata[37:0]);
        end
        if (m_tdata[101:38] !== want.lo) begin
          error_count++;
          $display("%0t: kmer_low expected %h actual %h", $time, want.lo, m_tdata[101:38]);
        end
        if (m_tdata[133:102] !== want.pos) begin
          error_count++;
          $display("%0t: kmer_position expected %0d actual %0d", $time, want.pos,
                   m_tdata[133:102]);
        end
      end
    end
  end

  // extremes of the character byte, lowercase bases and other non-bases: no k-mers
  task automatic test_char_extremes();
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(8'h7F, 1'b0);
    push_char("a", 1'b0);
    push_char("c", 1'b0);
    push_char("g", 1'b0);
    push_char("t", 1'b0);
    push_char("N", 1'b1);
  endtask

  // one record per base letter, each one base longer than a k-mer
  task automatic test_uniform_runs();
    logic [7:0] letters[4];
    letters = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
    foreach (letters[j])
      for (int i = 0; i < KMER_LEN + 1; i++) push_char(letters[j], i == 0);
  endtask

  // run broken by a lowercase base, then a record restart in the middle of a run
  task automatic test_run_breaks();
    for (int i = 0; i < KMER_LEN + 4; i++) push_char(pick_base(), i == 0);
    push_char("a", 1'b0);
    for (int i = 0; i < KMER_LEN + 4; i++) push_char(pick_base(), 1'b0);
    for (int i = 0; i < KMER_LEN + 4; i++) push_char(pick_base(), i == 0);
  endtask

  // long output stall while the sender keeps offering bases, so the input backs up
  task automatic test_output_stall();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < KMER_LEN + 70; i++) push_char(pick_base(), i == 0);
    s_tvalid <= 1'b0;
    wait (!hold_req);
    @(negedge clk);
    idle_on = 1'b1;
  endtask

  // stretch with no idling at all on either side
  task automatic test_no_idle();
    idle_on = 1'b0;
    for (int i = 0; i < 300; i++)
      push_char(($urandom_range(99) < 3) ? pick_non_base() : pick_base(), i == 0);
    idle_on = 1'b1;
  endtask

  // mostly well-formed records with random bases, some short records, some raw noise
  task automatic test_random_records();
    int target;
    int len;
    int kind;
    target = sent_words + 1100;
    while (sent_words < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(KMER_LEN, 3 * KMER_LEN);
        for (int i = 0; i < len; i++)
          push_char(($urandom_range(99) < 2) ? pick_non_base() : pick_base(),
                    (i == 0) && ($urandom_range(3) != 0));
      end else if (kind < 90) begin
        len = $urandom_range(1, KMER_LEN + 5);
        for (int i = 0; i < len; i++)
          push_char(($urandom_range(99) < 10) ? 8'($urandom_range(255)) : pick_base(), i == 0);
      end else begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
          push_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tuser       = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    sent_words    = 0;
    checked_kmers = 0;
    error_count   = 0;
    cycle_count   = 0;
    fwd_win       = '0;
    rc_win        = '0;
    base_run      = 0;
    rec_offset    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_char_extremes();
    test_uniform_runs();
    test_run_breaks();
    test_output_stall();
    test_no_idle();
    test_random_records();

    // drain, then wait for any stray word
    s_tvalid <= 1'b0;
    while (pending_kmers.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d character words, checked %0d k-mer words", sent_words, checked_kmers);
    $display("covered byte extremes, run breaks, record restarts, random records and a %0d-cycle output stall",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("canonical_kmer_stream: match");
    end else begin
      $display("canonical_kmer_stream: mismatch");
    end
    $finish;
  end

endmodule
